### hw/rtl/sslr_pkg.sv
// ----------------------------------------------------------------------------
// sslr_pkg
// Shared constants, codes and types of the seed segment label rasterizer.
// ----------------------------------------------------------------------------
package sslr_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 16;
  localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(MAP_DEPTH);

  localparam int COORD_W   = 9;
  localparam int DIM_W     = 10;
  localparam int IDX_W     = 18;
  localparam int CFG_IDX_W = 8;
  localparam int LEN2_W    = 20;
  localparam int ROOT_W    = LEN2_W / 2 + FRAC_BITS;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DIVD_W    = COORD_W + 2 * FRAC_BITS;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int UNIT_W    = QUO_W + 1;
  localparam int POS_W     = COORD_W + FRAC_BITS + 3;
  localparam int T_W       = 11;
  localparam int T2_W      = LEN2_W + 1;
  localparam int CNT_W     = 6;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_MARK  = 2'd3;

  localparam logic [1:0] LABEL_NONE = 2'd0;
  localparam logic [1:0] LABEL_FG   = 2'd1;
  localparam logic [1:0] LABEL_BG   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } map_req_t;

endpackage

### hw/rtl/sslr_in_if.sv
// ----------------------------------------------------------------------------
// sslr_in_if
// Operation channel: function code, segment end points, label and index.
// ----------------------------------------------------------------------------
interface sslr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [8:0]  x_start;
  logic [8:0]  y_start;
  logic [8:0]  x_end;
  logic [8:0]  y_end;
  logic        seed_kind;
  logic [17:0] pixel_index;

  modport source (output valid, func, x_start, y_start, x_end, y_end, seed_kind,
                  pixel_index, input ready);
  modport sink (input valid, func, x_start, y_start, x_end, y_end, seed_kind,
                pixel_index, output ready);
endinterface

### hw/rtl/sslr_out_if.sv
// ----------------------------------------------------------------------------
// sslr_out_if
// Result channel: label read and clip flag.
// ----------------------------------------------------------------------------
interface sslr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] pixel_label;
  logic       is_seed;
  logic       is_foreground;
  logic       clipped;

  modport source (output valid, pixel_label, is_seed, is_foreground, clipped,
                  input ready);
  modport sink (input valid, pixel_label, is_seed, is_foreground, clipped,
                output ready);
endinterface

### hw/rtl/sslr_cfg_if.sv
// ----------------------------------------------------------------------------
// sslr_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sslr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/sslr_map.sv
// ----------------------------------------------------------------------------
// sslr_map
// Label map storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sslr_map (
  input  logic              clk,
  input  sslr_pkg::map_req_t req,
  output logic [1:0]        rd_data
);
  import sslr_pkg::*;

  logic [1:0] mem [MAP_DEPTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/seed_segment_label_rasterizer.sv
// ----------------------------------------------------------------------------
// seed_segment_label_rasterizer
// Keeps a 2-bit seed label map and draws, reads and marks it.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_if   | in  | valid / ready | func, x_start, y_start, x_end, y_end,
//          |     |               | seed_kind, pixel_index
//  out_if  | out | valid / ready | pixel_label, is_seed, is_foreground, clipped
//  cfg_if  | in  | valid / ready | index, data (always ready)
//
//  read: index check, map read; mark, index outside the image: check only
//  clear: one map entry per cycle; zero-length draw: length only
//  draw: length, square root, x and y divides, walk; root and divides
//  all on one shared trial-subtract unit, one map write per in-image step
//  after reset the map is swept to zero, in_if not ready
//  a finished result waits in the output register; the next transaction
//  is taken while it waits
// ----------------------------------------------------------------------------
module seed_segment_label_rasterizer (
  input  logic clk,
  input  logic rst_n,
  sslr_in_if.sink    in_if,
  sslr_out_if.source out_if,
  sslr_cfg_if.sink   cfg_if
);
  import sslr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_LEN  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_DIVX = 4'd4;
  localparam logic [3:0] S_DIVY = 4'd5;
  localparam logic [3:0] S_WALK = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_RDW  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic clr_resp_r, clr_resp_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [DIM_W-1:0] wid_r, wid_nxt, hgt_r, hgt_nxt;

  logic [1:0] func_r, func_nxt;
  logic [COORD_W-1:0] xs_r, xs_nxt, ys_r, ys_nxt, adx_r, adx_nxt, ady_r, ady_nxt;
  logic sx_r, sx_nxt, sy_r, sy_nxt;
  logic [1:0] label_r, label_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LEN2_W-1:0] len2_r, len2_nxt, pair_sh_r, pair_sh_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [DIVD_W-1:0] divd_r, divd_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [UNIT_W-1:0] ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [T_W-1:0] t_r, t_nxt;
  logic [T2_W-1:0] t2_r, t2_nxt;
  logic clip_r, clip_nxt;
  logic [1:0] lab_r, lab_nxt;
  logic [1:0] out_lab_r, out_lab_nxt;
  logic out_clip_r, out_clip_nxt;

  // shared trial-subtract unit
  logic [REM_W-1:0] op_a, op_b;
  logic [REM_W:0] diff;
  logic ge;

  logic [POS_W-FRAC_BITS-1:0] col, row;
  logic oob;
  logic [2*DIM_W-1:0] addr_full, area;
  logic [LEN2_W-1:0] len2_calc;
  logic signed [UNIT_W-1:0] unit_val;
  logic [1:0] rd_data;
  map_req_t map_req;

  always_comb begin
    if (state_r == S_SQRT) begin
      op_a = {rem_r[REM_W-3:0], pair_sh_r[LEN2_W-1 -: 2]};
      op_b = {root_r, 2'b01};
    end else begin
      op_a = {rem_r[REM_W-2:0], divd_r[DIVD_W-1]};
      op_b = {2'b00, root_r};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = !diff[REM_W];
  end

  assign col  = px_r[POS_W-1:FRAC_BITS];
  assign row  = py_r[POS_W-1:FRAC_BITS];
  assign oob  = px_r[POS_W-1] || py_r[POS_W-1] ||
                (col >= (POS_W-FRAC_BITS)'(wid_r)) || (row >= (POS_W-FRAC_BITS)'(hgt_r));
  assign addr_full = (2*DIM_W)'(col[DIM_W-1:0]) + wid_r * row[DIM_W-1:0];
  assign area      = wid_r * hgt_r;
  assign len2_calc = LEN2_W'(adx_r) * LEN2_W'(adx_r) + LEN2_W'(ady_r) * LEN2_W'(ady_r);
  assign unit_val  = ((state_r == S_DIVX) ? sx_r : sy_r) ?
                     -$signed({1'b0, quo_nxt}) : $signed({1'b0, quo_nxt});

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;   clr_cnt_nxt = clr_cnt_r; clr_resp_nxt = clr_resp_r;
    out_valid_nxt = out_valid_r; wid_nxt = wid_r; hgt_nxt = hgt_r;
    func_nxt = func_r; xs_nxt = xs_r; ys_nxt = ys_r; adx_nxt = adx_r; ady_nxt = ady_r;
    sx_nxt = sx_r; sy_nxt = sy_r; label_nxt = label_r; idx_nxt = idx_r;
    len2_nxt = len2_r; pair_sh_nxt = pair_sh_r; rem_nxt = rem_r; root_nxt = root_r;
    divd_nxt = divd_r; quo_nxt = quo_r; cnt_nxt = cnt_r; ux_nxt = ux_r; uy_nxt = uy_r;
    px_nxt = px_r; py_nxt = py_r; t_nxt = t_r; t2_nxt = t2_r; clip_nxt = clip_r;
    lab_nxt = lab_r; out_lab_nxt = out_lab_r; out_clip_nxt = out_clip_r;
    map_req = '0;

    if (cfg_if.valid) begin
      if (cfg_if.index == REG_WIDTH) begin
        wid_nxt = (cfg_if.data > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_if.data;
      end else if (cfg_if.index == REG_HEIGHT) begin
        hgt_nxt = (cfg_if.data > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_if.data;
      end
    end

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (state_r == S_SQRT || state_r == S_DIVX || state_r == S_DIVY) begin
      rem_nxt = ge ? diff[REM_W-1:0] : op_a;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          func_nxt  = in_if.func;
          xs_nxt    = in_if.x_start;
          ys_nxt    = in_if.y_start;
          sx_nxt    = in_if.x_end < in_if.x_start;
          sy_nxt    = in_if.y_end < in_if.y_start;
          adx_nxt   = (in_if.x_end < in_if.x_start) ? in_if.x_start - in_if.x_end
                                                    : in_if.x_end - in_if.x_start;
          ady_nxt   = (in_if.y_end < in_if.y_start) ? in_if.y_start - in_if.y_end
                                                    : in_if.y_end - in_if.y_start;
          label_nxt = in_if.seed_kind ? LABEL_BG : LABEL_FG;
          idx_nxt   = in_if.pixel_index;
          clip_nxt  = 1'b0;
          lab_nxt   = LABEL_NONE;
          unique case (in_if.func)
            FUNC_CLEAR: begin
              state_nxt    = S_CLR;
              clr_cnt_nxt  = '0;
              clr_resp_nxt = 1'b1;
            end
            FUNC_DRAW: state_nxt = S_LEN;
            default:   state_nxt = S_CHK;
          endcase
        end
      end
      S_CLR: begin
        map_req.we    = 1'b1;
        map_req.waddr = clr_cnt_r;
        map_req.wdata = LABEL_NONE;
        clr_cnt_nxt   = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(MAP_DEPTH - 1)) begin
          state_nxt    = clr_resp_r ? S_OUT : S_IDLE;
          clr_resp_nxt = 1'b0;
        end
      end
      S_LEN: begin
        len2_nxt    = len2_calc;
        pair_sh_nxt = len2_calc;
        rem_nxt     = '0;
        root_nxt    = '0;
        cnt_nxt     = CNT_W'(ROOT_W - 1);
        state_nxt   = (len2_calc == '0) ? S_OUT : S_SQRT;
      end
      S_SQRT: begin
        root_nxt    = {root_r[ROOT_W-2:0], ge};
        pair_sh_nxt = {pair_sh_r[LEN2_W-3:0], 2'b00};
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DIVX;
          rem_nxt   = '0;
          divd_nxt  = {adx_r, (2*FRAC_BITS)'(0)};
          quo_nxt   = '0;
          cnt_nxt   = CNT_W'(DIVD_W - 1);
        end
      end
      S_DIVX, S_DIVY: begin
        divd_nxt = {divd_r[DIVD_W-2:0], 1'b0};
        quo_nxt  = {quo_r[QUO_W-2:0], ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (state_r == S_DIVX) begin
            ux_nxt    = unit_val;
            state_nxt = S_DIVY;
            rem_nxt   = '0;
            divd_nxt  = {ady_r, (2*FRAC_BITS)'(0)};
            cnt_nxt   = CNT_W'(DIVD_W - 1);
          end else begin
            uy_nxt    = unit_val;
            state_nxt = S_WALK;
            px_nxt    = POS_W'({xs_r, FRAC_BITS'(0)});
            py_nxt    = POS_W'({ys_r, FRAC_BITS'(0)});
            t_nxt     = '0;
            t2_nxt    = '0;
          end
        end
      end
      S_WALK: begin
        if (t2_r < T2_W'(len2_r)) begin
          if (oob) begin
            clip_nxt = 1'b1;
          end else begin
            map_req.we    = 1'b1;
            map_req.waddr = addr_full[ADDR_W-1:0];
            map_req.wdata = label_r;
          end
          px_nxt = px_r + POS_W'(ux_r);
          py_nxt = py_r + POS_W'(uy_r);
          t2_nxt = t2_r + T2_W'({t_r, 1'b1});
          t_nxt  = t_r + 1'b1;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_CHK: begin
        if (T2_W'(idx_r) >= T2_W'(area)) begin
          clip_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else if (func_r == FUNC_READ) begin
          map_req.re    = 1'b1;
          map_req.raddr = idx_r[ADDR_W-1:0];
          state_nxt     = S_RDW;
        end else begin
          map_req.we    = 1'b1;
          map_req.waddr = idx_r[ADDR_W-1:0];
          map_req.wdata = LABEL_FG;
          state_nxt     = S_OUT;
        end
      end
      S_RDW: begin
        lab_nxt   = rd_data;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_lab_nxt   = lab_r;
          out_clip_nxt  = clip_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wid_r       <= DIM_W'(MAX_WIDTH < 512 ? MAX_WIDTH : 512);
      hgt_r       <= DIM_W'(MAX_HEIGHT < 512 ? MAX_HEIGHT : 512);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
      wid_r       <= wid_nxt;
      hgt_r       <= hgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt; xs_r <= xs_nxt; ys_r <= ys_nxt; adx_r <= adx_nxt; ady_r <= ady_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; label_r <= label_nxt; idx_r <= idx_nxt;
    len2_r <= len2_nxt; pair_sh_r <= pair_sh_nxt; rem_r <= rem_nxt; root_r <= root_nxt;
    divd_r <= divd_nxt; quo_r <= quo_nxt; cnt_r <= cnt_nxt; ux_r <= ux_nxt; uy_r <= uy_nxt;
    px_r <= px_nxt; py_r <= py_nxt; t_r <= t_nxt; t2_r <= t2_nxt; clip_r <= clip_nxt;
    lab_r <= lab_nxt; out_lab_r <= out_lab_nxt; out_clip_r <= out_clip_nxt;
  end

  sslr_map u_map (
    .clk     (clk),
    .req     (map_req),
    .rd_data (rd_data)
  );

  assign out_if.valid         = out_valid_r;
  assign out_if.pixel_label   = out_lab_r;
  assign out_if.is_seed       = (out_lab_r != LABEL_NONE);
  assign out_if.is_foreground = (out_lab_r == LABEL_FG);
  assign out_if.clipped       = out_clip_r;

`ifndef SYNTHESIS
  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_if.ready)
    else $error("input ready during map clear");

  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    map_req.we |-> (state_r == S_CLR || state_r == S_WALK || state_r == S_CHK))
    else $error("map write outside clear, walk or mark");

  a_label_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.pixel_label != 2'd3))
    else $error("invalid label code on result");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives segment draws, pixel reads, marks and map clears into the seed label
// rasterizer across several image sizes, keeps a shadow label map updated by a
// fixed-point line walker, and checks every result against it in order.
// ----------------------------------------------------------------------------
module testbench;
  import sslr_pkg::*;

  localparam int  HALF_PERIOD  = 6;
  localparam int  RESET_CYCLES = 3;
  localparam longint CYCLE_LIMIT = 20000000;
  localparam int  RAND_PER_PHASE = 160;

  typedef struct {
    logic [1:0]       func;
    logic [8:0]       xs;
    logic [8:0]       ys;
    logic [8:0]       xe;
    logic [8:0]       ye;
    logic             kind;
    logic [IDX_W-1:0] pix;
  } seed_op_t;

  typedef struct {
    logic [1:0] label;
    logic       seed;
    logic       fg;
    logic       clip;
  } pixel_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sslr_in_if  in_if ();
  sslr_out_if out_if ();
  sslr_cfg_if cfg_if ();

  seed_segment_label_rasterizer dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // shadow state of the block
  logic [1:0]  shadow_map [0:MAP_DEPTH-1];
  int unsigned img_w = 512;
  int unsigned img_h = 512;

  seed_op_t   op_pending [$];
  pixel_res_t res_waiting [$];
  int unsigned painted_idx [$];

  int  n_fail = 0;
  int  n_in = 0;
  int  n_out = 0;
  int  n_clip = 0;
  int  n_hit = 0;
  int  n_cfg = 0;
  longint n_cycles = 0;
  bit  in_fire = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // floor(sqrt(len2 * 2^(2F))) bit by bit
  function automatic longint unsigned length_q(longint unsigned len2);
    longint unsigned rem_v, root_v, trial, pair;
    rem_v = 0;
    root_v = 0;
    for (int k = 0; k < LEN2_W / 2 + FRAC_BITS; k++) begin
      pair = 0;
      if (k < LEN2_W / 2) pair = (len2 >> (2 * (LEN2_W / 2 - 1 - k))) & 3;
      rem_v = (rem_v << 2) | pair;
      trial = (root_v << 2) | 1;
      if (rem_v >= trial) begin
        rem_v -= trial;
        root_v = (root_v << 1) | 1;
      end else begin
        root_v = root_v << 1;
      end
    end
    return root_v;
  endfunction

  function automatic longint unit_q(longint d, longint unsigned len_q);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = (mag << (2 * FRAC_BITS)) / len_q;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit walk_segment(seed_op_t op);
    longint dx, dy, ux, uy, px, py;
    longint unsigned len2, lq, col, row;
    logic [1:0] lab;
    bit clip;
    clip = 1'b0;
    dx = longint'(op.xe) - longint'(op.xs);
    dy = longint'(op.ye) - longint'(op.ys);
    len2 = dx * dx + dy * dy;
    if (len2 == 0) return 1'b0;
    lab = op.kind ? LABEL_BG : LABEL_FG;
    lq = length_q(len2);
    ux = unit_q(dx, lq);
    uy = unit_q(dy, lq);
    for (longint unsigned t = 0; t * t < len2; t++) begin
      px = (longint'(op.xs) << FRAC_BITS) + ux * longint'(t);
      py = (longint'(op.ys) << FRAC_BITS) + uy * longint'(t);
      if (px < 0 || py < 0) begin
        clip = 1'b1;
      end else begin
        col = px >> FRAC_BITS;
        row = py >> FRAC_BITS;
        if (col >= img_w || row >= img_h) clip = 1'b1;
        else shadow_map[col + img_w * row] = lab;
      end
    end
    return clip;
  endfunction

  function automatic pixel_res_t apply_op(seed_op_t op);
    pixel_res_t r;
    r = '{label: LABEL_NONE, seed: 1'b0, fg: 1'b0, clip: 1'b0};
    if (op.func == FUNC_CLEAR) begin
      foreach (shadow_map[i]) shadow_map[i] = LABEL_NONE;
    end else if (op.func == FUNC_DRAW) begin
      r.clip = walk_segment(op);
    end else if (op.pix >= img_w * img_h) begin
      r.clip = 1'b1;
    end else if (op.func == FUNC_READ) begin
      r.label = shadow_map[op.pix];
    end else begin
      shadow_map[op.pix] = LABEL_FG;
    end
    r.seed = (r.label != LABEL_NONE);
    r.fg = (r.label == LABEL_FG);
    return r;
  endfunction

  // sampling at the rising edge: configuration, results, then new operations
  always @(posedge clk) begin
    pixel_res_t want;
    in_fire = in_if.valid && in_if.ready;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        n_cfg++;
        if (cfg_if.index == REG_WIDTH)
          img_w = (cfg_if.data > MAX_WIDTH) ? MAX_WIDTH : cfg_if.data;
        else if (cfg_if.index == REG_HEIGHT)
          img_h = (cfg_if.data > MAX_HEIGHT) ? MAX_HEIGHT : cfg_if.data;
      end
      if (out_if.valid && out_if.ready) begin
        n_out++;
        if (res_waiting.size() == 0) begin
          $error("result transaction with no expectation waiting");
          n_fail++;
        end else begin
          want = res_waiting.pop_front();
          if (out_if.pixel_label !== want.label) begin
            $error("pixel_label: expected %0d, got %0d", want.label, out_if.pixel_label);
            n_fail++;
          end
          if (out_if.is_seed !== want.seed) begin
            $error("is_seed: expected %0d, got %0d", want.seed, out_if.is_seed);
            n_fail++;
          end
          if (out_if.is_foreground !== want.fg) begin
            $error("is_foreground: expected %0d, got %0d", want.fg, out_if.is_foreground);
            n_fail++;
          end
          if (out_if.clipped !== want.clip) begin
            $error("clipped: expected %0d, got %0d", want.clip, out_if.clipped);
            n_fail++;
          end
        end
      end
      if (in_fire) begin
        n_in++;
        want = apply_op('{func: in_if.func, xs: in_if.x_start, ys: in_if.y_start,
                          xe: in_if.x_end, ye: in_if.y_end, kind: in_if.seed_kind,
                          pix: in_if.pixel_index});
        if (want.clip) n_clip++;
        if (want.seed) n_hit++;
        res_waiting.push_back(want);
      end
    end
  end

  // operation driver
  always @(negedge clk) begin
    seed_op_t op;
    if (!rst_n || (in_if.valid && !in_fire)) begin
      // hold the current transaction
    end else if (send_gap > 0) begin
      send_gap--;
      in_if.valid <= 1'b0;
    end else if (op_pending.size() != 0) begin
      op = op_pending.pop_front();
      in_if.valid       <= 1'b1;
      in_if.func        <= op.func;
      in_if.x_start     <= op.xs;
      in_if.y_start     <= op.ys;
      in_if.x_end       <= op.xe;
      in_if.y_end       <= op.ye;
      in_if.seed_kind   <= op.kind;
      in_if.pixel_index <= op.pix;
      send_gap = pick_gap();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result receiver, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else if (!hold_done && n_in >= 300) begin
      hold_done = 1'b1;
      hold_cnt = 400;
      out_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      recv_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               res_waiting.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_op(logic [1:0] f, int xs, int ys, int xe, int ye, bit k, int pix);
    op_pending.push_back('{func: f, xs: 9'(xs), ys: 9'(ys), xe: 9'(xe), ye: 9'(ye),
                           kind: k, pix: IDX_W'(pix)});
  endtask

  task automatic add_noise_op(logic [1:0] f, int pix);
    add_op(f, $urandom_range(511), $urandom_range(511), $urandom_range(511),
           $urandom_range(511), 1'($urandom_range(1)), pix);
  endtask

  task automatic add_segment(int xs, int ys, bit k);
    int xe, ye;
    if ($urandom_range(19) == 0) begin
      xe = $urandom_range(511);
      ye = $urandom_range(511);
    end else begin
      xe = xs + $urandom_range(40) - 20;
      ye = ys + $urandom_range(40) - 20;
      if (xe < 0) xe = 0;
      if (xe > 511) xe = 511;
      if (ye < 0) ye = 0;
      if (ye > 511) ye = 511;
    end
    add_op(FUNC_DRAW, xs, ys, xe, ye, k, $urandom_range(262143));
    if (xs < img_w && ys < img_h) painted_idx.push_back(xs + img_w * ys);
  endtask

  // polylines (foreground run, then background run), reads and marks
  task automatic gen_random(int count);
    int left, x, y, nseg, r;
    int unsigned area;
    left = count;
    area = img_w * img_h;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 55) begin
        for (int k = 0; k < 2; k++) begin
          nseg = $urandom_range(4, 1);
          x = (img_w > 0) ? $urandom_range(img_w - 1) : $urandom_range(511);
          y = (img_h > 0) ? $urandom_range(img_h - 1) : $urandom_range(511);
          if ($urandom_range(7) == 0) begin
            x = $urandom_range(511);
            y = $urandom_range(511);
          end
          for (int s = 0; s < nseg; s++) add_segment(x, y, k[0]);
          left -= nseg;
        end
      end else if (r < 80 && painted_idx.size() != 0) begin
        add_noise_op(FUNC_READ, painted_idx[$urandom_range(painted_idx.size() - 1)]);
        left--;
      end else if (r < 88) begin
        add_noise_op($urandom_range(1) ? FUNC_MARK : FUNC_READ,
                     (area > 0) ? $urandom_range(area - 1) : 0);
        left--;
      end else begin
        add_noise_op($urandom_range(1) ? FUNC_MARK : FUNC_READ, $urandom_range(262143));
        left--;
      end
      if (painted_idx.size() > 64) void'(painted_idx.pop_front());
    end
  endtask

  task automatic drain();
    while (op_pending.size() != 0 || in_if.valid || res_waiting.size() != 0)
      @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [9:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_size(int w, int h);
    write_reg(REG_WIDTH, 10'(w));
    write_reg(REG_HEIGHT, 10'(h));
    write_reg(8'd7, 10'($urandom_range(1023)));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    painted_idx.delete();
  endtask

  int size_list [7][2] = '{'{1023, 1023}, '{37, 300}, '{0, 5}, '{1, 1},
                          '{512, 100}, '{200, 0}, '{301, 512}};

  initial begin
    in_if.valid = 1'b0;
    in_if.func = FUNC_CLEAR;
    in_if.x_start = '0;
    in_if.y_start = '0;
    in_if.x_end = '0;
    in_if.y_end = '0;
    in_if.seed_kind = 1'b0;
    in_if.pixel_index = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    foreach (shadow_map[i]) shadow_map[i] = LABEL_NONE;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, each operation, an empty segment
    add_op(FUNC_DRAW, 0, 0, 511, 511, 0, 0);
    add_op(FUNC_DRAW, 511, 0, 0, 511, 1, 262143);
    add_op(FUNC_DRAW, 10, 20, 10, 20, 0, 0);
    add_op(FUNC_DRAW, 511, 511, 0, 511, 1, 0);
    add_op(FUNC_DRAW, 5, 511, 5, 0, 0, 0);
    add_op(FUNC_DRAW, 100, 200, 97, 190, 1, 0);
    add_op(FUNC_READ, 0, 0, 0, 0, 0, 0);
    add_op(FUNC_READ, 0, 0, 0, 0, 0, 511);
    add_op(FUNC_READ, 0, 0, 0, 0, 0, 511 * 512 + 511);
    add_op(FUNC_READ, 0, 0, 0, 0, 0, 5 + 512 * 300);
    add_op(FUNC_READ, 0, 0, 0, 0, 0, 100 + 512 * 200);
    add_op(FUNC_READ, 0, 0, 0, 0, 0, 10 + 512 * 20);
    add_op(FUNC_MARK, 511, 511, 511, 511, 1, 262143);
    add_op(FUNC_READ, 511, 511, 511, 511, 1, 262143);
    add_op(FUNC_MARK, 0, 0, 0, 0, 0, 1 + 512 * 1);
    add_op(FUNC_READ, 0, 0, 0, 0, 0, 1 + 512 * 1);
    add_op(FUNC_CLEAR, 511, 511, 511, 511, 1, 262143);
    add_op(FUNC_READ, 0, 0, 0, 0, 0, 511 * 512 + 511);
    add_op(FUNC_READ, 0, 0, 0, 0, 0, 0);
    drain();
    gen_random(RAND_PER_PHASE);
    drain();

    foreach (size_list[p]) begin
      set_size(size_list[p][0], size_list[p][1]);
      add_op(FUNC_DRAW, 0, 0, 511, 511, 0, 0);
      add_op(FUNC_READ, 0, 0, 0, 0, 0, 262143);
      add_op(FUNC_MARK, 0, 0, 0, 0, 0, 0);
      add_op(FUNC_READ, 0, 0, 0, 0, 0, 0);
      gen_random(RAND_PER_PHASE);
      if (p == 3) add_op(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
      drain();
    end

    $display("covered %0d operations over %0d register writes and %0d image sizes",
             n_in, n_cfg, 8);
    $display("%0d results checked, %0d clipped, %0d reads found a seed",
             n_out, n_clip, n_hit);
    if (n_fail == 0 && res_waiting.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
